[rtl/hmq_pkg.sv]
// shared constants and control types for the binary min-heap queue
`default_nettype none

package hmq_pkg;

    // default sizes
    localparam int DEF_HEAP_DEPTH   = 64;
    localparam int DEF_KEY_BITS     = 16;
    localparam int DEF_PAYLOAD_BITS = 8;

    // result status codes
    localparam int STATUS_BITS = 2;
    localparam logic [STATUS_BITS-1:0] STATUS_DONE  = 2'd0;
    localparam logic [STATUS_BITS-1:0] STATUS_EMPTY = 2'd1;
    localparam logic [STATUS_BITS-1:0] STATUS_FULL  = 2'd2;

    // operation codes
    localparam logic MODE_PUSH = 1'b0;
    localparam logic MODE_POP  = 1'b1;

    // controller to datapath commands
    typedef struct packed {
        logic accept;
        logic pop_rd;
        logic pop_ld;
        logic down_rd;
        logic down_cmp;
        logic up_rd;
        logic up_cmp;
        logic load_out;
    } hmq_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic full;
        logic empty;
        logic last_one;
        logic pos_zero;
        logic leaf;
        logic up_move;
        logic down_move;
    } hmq_stat_t;

endpackage

`default_nettype wire

[rtl/binary_min_heap_queue_core.sv]
// top level of the binary min-heap priority queue
//
// usage
//   input channel (s_*): one transfer is one operation; s_mode selects push
//   (s_key, s_payload stored) or pop (s_key, s_payload ignored)
//   result channel (m_*): exactly one transfer per operation, in order;
//   m_out_key / m_out_payload carry the popped entry, else zero; m_status
//   is done, pop on empty heap, or push on full heap; m_fill is the entry
//   count after the operation
// sequencing
//   one operation at a time; each heap level takes a read state (read the
//   parent or both children from the entry store), then a compare-and-write state
//   push: sift-up from the new leaf (UP_RD, UP_CMP per level), then DONE
//   pop: read root and last entry (POP_RD, POP_LD), sift-down, then DONE
//   rejected operations go straight to DONE; s_ready is high again in IDLE
// reset and stalls
//   reset empties the heap (count to zero) and drops any pending result;
//   the store contents are not cleared, only entries below the count are read
//   a stalled receiver holds the result register; the next operation is
//   still taken and runs, then waits in its final state for the register
`default_nettype none

module binary_min_heap_queue_core #(
    parameter int HEAP_DEPTH   = hmq_pkg::DEF_HEAP_DEPTH,
    parameter int KEY_BITS     = hmq_pkg::DEF_KEY_BITS,
    parameter int PAYLOAD_BITS = hmq_pkg::DEF_PAYLOAD_BITS
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // operation channel
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire logic                            s_mode,
    input  wire logic [KEY_BITS-1:0]             s_key,
    input  wire logic [PAYLOAD_BITS-1:0]         s_payload,
    // result channel
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic      [KEY_BITS-1:0]             m_out_key,
    output logic      [PAYLOAD_BITS-1:0]         m_out_payload,
    output logic      [hmq_pkg::STATUS_BITS-1:0] m_status,
    output logic      [$clog2(HEAP_DEPTH+1)-1:0] m_fill
);

    hmq_pkg::hmq_cmd_t  cmd;
    hmq_pkg::hmq_stat_t stat;

    // sequencing: one state per memory step of a sift
    hmq_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_mode  (s_mode),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // entry store, moving entry (hole-based sift), result register
    hmq_datapath #(
        .HEAP_DEPTH   (HEAP_DEPTH),
        .KEY_BITS     (KEY_BITS),
        .PAYLOAD_BITS (PAYLOAD_BITS)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .stat          (stat),
        .s_mode        (s_mode),
        .s_key         (s_key),
        .s_payload     (s_payload),
        .m_out_key     (m_out_key),
        .m_out_payload (m_out_payload),
        .m_status      (m_status),
        .m_fill        (m_fill)
    );

endmodule

`default_nettype wire

[rtl/hmq_ram.sv]
// generic ram: one write port, two registered read ports
`default_nettype none

module hmq_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
    output logic      [WIDTH-1:0]         rdata_a,
    input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic      [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

`default_nettype wire

[rtl/hmq_datapath.sv]
// heap datapath: entry count, moving entry, index math, store and result registers
`default_nettype none

module hmq_datapath #(
    parameter int HEAP_DEPTH   = hmq_pkg::DEF_HEAP_DEPTH,
    parameter int KEY_BITS     = hmq_pkg::DEF_KEY_BITS,
    parameter int PAYLOAD_BITS = hmq_pkg::DEF_PAYLOAD_BITS
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire hmq_pkg::hmq_cmd_t                    cmd,
    output hmq_pkg::hmq_stat_t                        stat,
    input  wire logic                                 s_mode,
    input  wire logic [KEY_BITS-1:0]                  s_key,
    input  wire logic [PAYLOAD_BITS-1:0]              s_payload,
    output logic      [KEY_BITS-1:0]                  m_out_key,
    output logic      [PAYLOAD_BITS-1:0]              m_out_payload,
    output logic      [hmq_pkg::STATUS_BITS-1:0]      m_status,
    output logic      [$clog2(HEAP_DEPTH+1)-1:0]      m_fill
);

    localparam int AW = $clog2(HEAP_DEPTH);
    localparam int CW = $clog2(HEAP_DEPTH + 1);
    localparam int EW = KEY_BITS + PAYLOAD_BITS;
    localparam int XW = AW + 2;

    logic [CW-1:0]                   count_reg, count_next;
    logic [AW-1:0]                   pos_reg, pos_next;
    logic [KEY_BITS-1:0]             mk_reg, mk_next;
    logic [PAYLOAD_BITS-1:0]         mp_reg, mp_next;
    logic [KEY_BITS-1:0]             rk_reg, rk_next;
    logic [PAYLOAD_BITS-1:0]         rp_reg, rp_next;
    logic [hmq_pkg::STATUS_BITS-1:0] st_reg, st_next;
    logic                            pop_ok_reg, pop_ok_next;
    logic [KEY_BITS-1:0]             ok_reg, ok_next;
    logic [PAYLOAD_BITS-1:0]         op_reg, op_next;
    logic [hmq_pkg::STATUS_BITS-1:0] os_reg, os_next;
    logic [CW-1:0]                   of_reg, of_next;

    logic [EW-1:0] rda, rdb, wdata;
    logic [AW-1:0] raddr_a, raddr_b, waddr;
    logic          we;

    logic [XW-1:0]       lc_idx, rc_idx, cnt_ext;
    logic [AW-1:0]       parent_idx;
    logic                rc_ok;
    logic [KEY_BITS-1:0] lk, rk, bk;
    logic                take_l, take_r;
    logic [EW-1:0]       moving;

    assign moving     = {mk_reg, mp_reg};
    assign lk         = rda[EW-1:PAYLOAD_BITS];
    assign rk         = rdb[EW-1:PAYLOAD_BITS];
    assign lc_idx     = {1'b0, pos_reg, 1'b1};
    assign rc_idx     = lc_idx + XW'(1);
    assign cnt_ext    = XW'(count_reg);
    assign rc_ok      = rc_idx < cnt_ext;
    assign parent_idx = AW'((pos_reg - AW'(1)) >> 1);

    // child selection, left tested first, strict compares only
    assign take_l = mk_reg > lk;
    assign bk     = take_l ? lk : mk_reg;
    assign take_r = rc_ok && (bk > rk);

    assign stat.full      = count_reg == CW'(HEAP_DEPTH);
    assign stat.empty     = count_reg == '0;
    assign stat.last_one  = count_reg == CW'(1);
    assign stat.pos_zero  = pos_reg == '0;
    assign stat.leaf      = lc_idx >= cnt_ext;
    assign stat.up_move   = mk_reg < lk;
    assign stat.down_move = take_l | take_r;

    // read addresses
    always_comb begin
        raddr_a = lc_idx[AW-1:0];
        raddr_b = rc_idx[AW-1:0];
        if (cmd.pop_rd) begin
            raddr_a = '0;
            raddr_b = AW'(count_reg - CW'(1));
        end else if (cmd.up_rd) begin
            raddr_a = parent_idx;
        end
    end

    // write port and moving-entry position
    always_comb begin
        we       = 1'b0;
        waddr    = pos_reg;
        wdata    = moving;
        pos_next = pos_reg;
        if (cmd.up_rd && stat.pos_zero) begin
            we = 1'b1;
        end
        if (cmd.up_cmp) begin
            we = 1'b1;
            if (stat.up_move) begin
                wdata    = rda;
                pos_next = parent_idx;
            end
        end
        if (cmd.down_rd && stat.leaf) begin
            we = 1'b1;
        end
        if (cmd.down_cmp) begin
            we = 1'b1;
            if (stat.down_move) begin
                wdata    = take_r ? rdb : rda;
                pos_next = take_r ? rc_idx[AW-1:0] : lc_idx[AW-1:0];
            end
        end
        if (cmd.accept) begin
            pos_next = AW'(count_reg);
        end
        if (cmd.pop_ld) begin
            pos_next = '0;
        end
    end

    always_comb begin
        count_next  = count_reg;
        mk_next     = mk_reg;
        mp_next     = mp_reg;
        rk_next     = rk_reg;
        rp_next     = rp_reg;
        st_next     = st_reg;
        pop_ok_next = pop_ok_reg;
        ok_next     = ok_reg;
        op_next     = op_reg;
        os_next     = os_reg;
        of_next     = of_reg;
        if (cmd.accept) begin
            mk_next = s_key;
            mp_next = s_payload;
            if (s_mode == hmq_pkg::MODE_POP) begin
                pop_ok_next = !stat.empty;
                st_next     = stat.empty ? hmq_pkg::STATUS_EMPTY : hmq_pkg::STATUS_DONE;
            end else begin
                pop_ok_next = 1'b0;
                st_next     = stat.full ? hmq_pkg::STATUS_FULL : hmq_pkg::STATUS_DONE;
                if (!stat.full) begin
                    count_next = count_reg + CW'(1);
                end
            end
        end
        if (cmd.pop_ld) begin
            rk_next    = lk;
            rp_next    = rda[PAYLOAD_BITS-1:0];
            mk_next    = rk;
            mp_next    = rdb[PAYLOAD_BITS-1:0];
            count_next = count_reg - CW'(1);
        end
        if (cmd.load_out) begin
            ok_next = pop_ok_reg ? rk_reg : '0;
            op_next = pop_ok_reg ? rp_reg : '0;
            os_next = st_reg;
            of_next = count_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
        pos_reg    <= pos_next;
        mk_reg     <= mk_next;
        mp_reg     <= mp_next;
        rk_reg     <= rk_next;
        rp_reg     <= rp_next;
        st_reg     <= st_next;
        pop_ok_reg <= pop_ok_next;
        ok_reg     <= ok_next;
        op_reg     <= op_next;
        os_reg     <= os_next;
        of_reg     <= of_next;
    end

    hmq_ram #(
        .WIDTH (EW),
        .DEPTH (HEAP_DEPTH)
    ) u_store (
        .aclk    (aclk),
        .we      (we),
        .waddr   (waddr),
        .wdata   (wdata),
        .raddr_a (raddr_a),
        .rdata_a (rda),
        .raddr_b (raddr_b),
        .rdata_b (rdb)
    );

    assign m_out_key     = ok_reg;
    assign m_out_payload = op_reg;
    assign m_status      = os_reg;
    assign m_fill        = of_reg;

endmodule

`default_nettype wire

[rtl/hmq_ctrl.sv]
// heap controller: sequences push sift-up, pop sift-down and result handoff
`default_nettype none

module hmq_ctrl (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic               s_mode,
    output logic                    m_valid,
    input  wire logic               m_ready,
    input  wire hmq_pkg::hmq_stat_t stat,
    output hmq_pkg::hmq_cmd_t       cmd
);

    typedef enum logic [2:0] {
        IDLE,
        POP_RD,
        POP_LD,
        DOWN_RD,
        DOWN_CMP,
        UP_RD,
        UP_CMP,
        DONE
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   reject;

    assign reject = (s_mode == hmq_pkg::MODE_POP) ? stat.empty : stat.full;

    always_comb begin
        state_next   = state_reg;
        cmd          = '0;
        cmd.accept   = (state_reg == IDLE) && s_valid;
        cmd.pop_rd   = state_reg == POP_RD;
        cmd.pop_ld   = state_reg == POP_LD;
        cmd.down_rd  = state_reg == DOWN_RD;
        cmd.down_cmp = state_reg == DOWN_CMP;
        cmd.up_rd    = state_reg == UP_RD;
        cmd.up_cmp   = state_reg == UP_CMP;
        cmd.load_out = (state_reg == DONE) && (!m_valid_reg || m_ready);
        unique case (state_reg)
            IDLE: begin
                if (s_valid) begin
                    if (reject) begin
                        state_next = DONE;
                    end else if (s_mode == hmq_pkg::MODE_POP) begin
                        state_next = POP_RD;
                    end else begin
                        state_next = UP_RD;
                    end
                end
            end
            POP_RD:   state_next = POP_LD;
            POP_LD:   state_next = stat.last_one ? DONE : DOWN_RD;
            DOWN_RD:  state_next = stat.leaf ? DONE : DOWN_CMP;
            DOWN_CMP: state_next = stat.down_move ? DOWN_RD : DONE;
            UP_RD:    state_next = stat.pos_zero ? DONE : UP_CMP;
            UP_CMP:   state_next = stat.up_move ? UP_RD : DONE;
            DONE: begin
                if (cmd.load_out) begin
                    state_next = IDLE;
                end
            end
            default:  state_next = IDLE;
        endcase
        if (cmd.load_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = state_reg == IDLE;
    assign m_valid = m_valid_reg;

endmodule

`default_nettype wire

[rtl/hmq_checker.sv]
// port-level checker for the heap queue and its bind to the top level
`default_nettype none

module hmq_checker #(
    parameter int HEAP_DEPTH   = hmq_pkg::DEF_HEAP_DEPTH,
    parameter int KEY_BITS     = hmq_pkg::DEF_KEY_BITS,
    parameter int PAYLOAD_BITS = hmq_pkg::DEF_PAYLOAD_BITS
) (
    input wire logic                            aclk,
    input wire logic                            aresetn,
    input wire logic                            m_valid,
    input wire logic                            m_ready,
    input wire logic [KEY_BITS-1:0]             m_out_key,
    input wire logic [PAYLOAD_BITS-1:0]         m_out_payload,
    input wire logic [hmq_pkg::STATUS_BITS-1:0] m_status,
    input wire logic [$clog2(HEAP_DEPTH+1)-1:0] m_fill
);

    localparam int CW = $clog2(HEAP_DEPTH + 1);

    // no result survives reset
    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_key)
            && $stable(m_out_payload) && $stable(m_status) && $stable(m_fill))
        else $error("stalled result changed");

    // failed pop only on an empty heap
    a_empty_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == hmq_pkg::STATUS_EMPTY |-> m_fill == '0)
        else $error("empty status with entries held");

    // failed push only on a full heap
    a_full_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == hmq_pkg::STATUS_FULL |-> m_fill == CW'(HEAP_DEPTH))
        else $error("full status below capacity");

    // failures carry no entry
    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != hmq_pkg::STATUS_DONE
            |-> m_out_key == '0 && m_out_payload == '0)
        else $error("failed operation returned an entry");

endmodule

bind binary_min_heap_queue_core hmq_checker #(
    .HEAP_DEPTH   (HEAP_DEPTH),
    .KEY_BITS     (KEY_BITS),
    .PAYLOAD_BITS (PAYLOAD_BITS)
) u_hmq_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_out_key     (m_out_key),
    .m_out_payload (m_out_payload),
    .m_status      (m_status),
    .m_fill        (m_fill)
);

`default_nettype wire

[bench/testbench.sv]
// testbench for the binary min-heap priority queue core
`timescale 1ns / 1ps

module testbench;

    localparam int HEAP_N   = hmq_pkg::DEF_HEAP_DEPTH;
    localparam int KEY_W    = hmq_pkg::DEF_KEY_BITS;
    localparam int PAY_W    = hmq_pkg::DEF_PAYLOAD_BITS;
    localparam int FILL_W   = $clog2(HEAP_N + 1);
    // cycles with no transfer on either channel before the run is declared hung;
    // well above the forced receiver hold-off plus the slowest sift
    localparam int HANG_LIMIT = 3000;
    localparam int HOLD_OFF   = 400;

    // one expected transfer on the result channel
    typedef struct packed {
        logic [KEY_W-1:0]                out_key;
        logic [PAY_W-1:0]                out_payload;
        logic [hmq_pkg::STATUS_BITS-1:0] status;
        logic [FILL_W-1:0]               fill;
    } heap_result_t;

    logic                            aclk      = 1'b0;
    logic                            aresetn   = 1'b0;
    logic                            s_valid   = 1'b0;
    logic                            s_ready;
    logic                            s_mode    = hmq_pkg::MODE_PUSH;
    logic [KEY_W-1:0]                s_key     = '0;
    logic [PAY_W-1:0]                s_payload = '0;
    logic                            m_valid;
    logic                            m_ready   = 1'b0;
    logic [KEY_W-1:0]                m_out_key;
    logic [PAY_W-1:0]                m_out_payload;
    logic [hmq_pkg::STATUS_BITS-1:0] m_status;
    logic [FILL_W-1:0]               m_fill;

    // shadow copy of the heap, updated at each accepted operation
    logic [KEY_W-1:0] shadow_keys [HEAP_N];
    logic [PAY_W-1:0] shadow_pays [HEAP_N];
    int               shadow_count = 0;

    // results still owed by the block, oldest first
    heap_result_t heap_results_due [$];

    int mismatch_count = 0;
    int hold_left      = 0;     // receiver hold-off still to run, in cycles
    bit calm_stretch   = 1'b0;  // both sides stop idling while set
    int quiet_cycles   = 0;

    binary_min_heap_queue_core dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_mode        (s_mode),
        .s_key         (s_key),
        .s_payload     (s_payload),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_key     (m_out_key),
        .m_out_payload (m_out_payload),
        .m_status      (m_status),
        .m_fill        (m_fill)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // heap predictor
    // ------------------------------------------------------------------

    function automatic void swap_entries(int a, int b);
        logic [KEY_W-1:0] k;
        logic [PAY_W-1:0] p;
        k = shadow_keys[a];
        p = shadow_pays[a];
        shadow_keys[a] = shadow_keys[b];
        shadow_pays[a] = shadow_pays[b];
        shadow_keys[b] = k;
        shadow_pays[b] = p;
    endfunction

    // applies one operation to the shadow heap and returns the result it owes
    function automatic heap_result_t heap_predict(logic mode, logic [KEY_W-1:0] key,
                                                  logic [PAY_W-1:0] pay);
        heap_result_t r;
        int pos, parent, cur, lc, rc, best;
        r = '0;
        if (mode == hmq_pkg::MODE_PUSH) begin
            if (shadow_count >= HEAP_N) begin
                r.status = hmq_pkg::STATUS_FULL;
            end else begin
                shadow_keys[shadow_count] = key;
                shadow_pays[shadow_count] = pay;
                pos = shadow_count;
                shadow_count++;
                // sift up only while strictly smaller than the parent
                while (pos > 0) begin
                    parent = (pos - 1) / 2;
                    if (shadow_keys[pos] >= shadow_keys[parent]) break;
                    swap_entries(pos, parent);
                    pos = parent;
                end
            end
        end else begin
            if (shadow_count == 0) begin
                r.status = hmq_pkg::STATUS_EMPTY;
            end else begin
                r.out_key     = shadow_keys[0];
                r.out_payload = shadow_pays[0];
                shadow_count--;
                shadow_keys[0] = shadow_keys[shadow_count];
                shadow_pays[0] = shadow_pays[shadow_count];
                // sift down: left child first, a child wins only when strictly smaller
                cur = 0;
                forever begin
                    lc = 2 * cur + 1;
                    rc = 2 * cur + 2;
                    if (lc >= shadow_count) break;
                    best = cur;
                    if (shadow_keys[best] > shadow_keys[lc]) best = lc;
                    if (rc < shadow_count && shadow_keys[best] > shadow_keys[rc]) best = rc;
                    if (best == cur) break;
                    swap_entries(cur, best);
                    cur = best;
                end
            end
        end
        r.fill = FILL_W'(shadow_count);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // result checking, receiver and watchdog
    // ------------------------------------------------------------------

    function automatic void check_field(string field, int unsigned exp_v, int unsigned got_v);
        if (exp_v != got_v) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, exp_v, got_v);
            mismatch_count++;
        end
    endfunction

    // every result transfer is matched against the oldest owed result
    always @(posedge aclk) begin
        heap_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (heap_results_due.size() == 0) begin
                $display("%0t: result transfer with none owed, expected nothing, %s %0d %s %0d",
                         $time, "actual key", m_out_key, "status", m_status);
                mismatch_count++;
            end else begin
                want = heap_results_due.pop_front();
                check_field("out_key", want.out_key, m_out_key);
                check_field("out_payload", want.out_payload, m_out_payload);
                check_field("status", want.status, m_status);
                check_field("fill", want.fill, m_fill);
            end
        end
    end

    // receiver: random stalls, a forced hold-off on request, none while calm
    initial begin
        forever begin
            @(negedge aclk);
            if (hold_left > 0) begin
                m_ready <= 1'b0;
                hold_left--;
            end else begin
                m_ready <= calm_stretch || ($urandom_range(99) >= 6);
            end
        end
    end

    // ends a run in which nothing moves on either channel for too long
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= HANG_LIMIT) begin
            $display("testbench: errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    // offers one operation; entered and left just after a falling edge
    task automatic offer_op(logic mode, logic [KEY_W-1:0] key, logic [PAY_W-1:0] pay);
        heap_result_t r;
        // random sender gaps, valid low in between
        while (!calm_stretch && $urandom_range(99) < 6) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid   <= 1'b1;
        s_mode    <= mode;
        s_key     <= key;
        s_payload <= pay;
        do @(posedge aclk); while (!s_ready);
        r = heap_predict(mode, key, pay);
        heap_results_due.push_back(r);
        @(negedge aclk);
    endtask

    // stop offering and let every owed result come back
    task automatic settle();
        s_valid <= 1'b0;
        while (heap_results_due.size() != 0) @(negedge aclk);
    endtask

    // key shapes: full range, tiny range for ties, extremes, a narrow band
    function automatic logic [KEY_W-1:0] pick_key(int style);
        logic [KEY_W-1:0] k;
        case (style)
            1: k = KEY_W'($urandom_range(7));
            2: begin
                case ($urandom_range(5))
                    0: k = '0;
                    1: k = KEY_W'(1);
                    2: k = {1'b0, {(KEY_W-1){1'b1}}};
                    3: k = {1'b1, {(KEY_W-1){1'b0}}};
                    4: k = {{(KEY_W-1){1'b1}}, 1'b0};
                    default: k = '1;
                endcase
            end
            3: k = KEY_W'($urandom_range(1100, 1000));
            default: k = KEY_W'($urandom);
        endcase
        return k;
    endfunction

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // field extremes, both operations, equal keys, pop on an empty heap
    task automatic test_directed_ops();
        offer_op(hmq_pkg::MODE_POP, '1, '1);              // empty heap
        offer_op(hmq_pkg::MODE_PUSH, '0, '0);
        offer_op(hmq_pkg::MODE_PUSH, '1, '1);
        offer_op(hmq_pkg::MODE_PUSH, 16'h8000, 8'hAA);
        offer_op(hmq_pkg::MODE_PUSH, 16'h0001, 8'h55);
        // three equal keys: the earlier position must win
        offer_op(hmq_pkg::MODE_PUSH, 16'd5, 8'd1);
        offer_op(hmq_pkg::MODE_PUSH, 16'd5, 8'd2);
        offer_op(hmq_pkg::MODE_PUSH, 16'd5, 8'd3);
        offer_op(hmq_pkg::MODE_PUSH, 16'h7FFF, 8'h80);
        repeat (8) offer_op(hmq_pkg::MODE_POP, '0, '0);
        offer_op(hmq_pkg::MODE_POP, '0, '0);              // empty again
        offer_op(hmq_pkg::MODE_PUSH, '1, 8'h00);
        offer_op(hmq_pkg::MODE_PUSH, '0, 8'hFF);
        offer_op(hmq_pkg::MODE_POP, 16'h1234, 8'h5A);
        offer_op(hmq_pkg::MODE_POP, '0, '0);
        settle();
    endtask

    // push past full, then pop past empty; popped keys must come out ordered
    task automatic test_fill_to_full(bit no_idle, int style);
        calm_stretch = no_idle;
        repeat (HEAP_N + 2) offer_op(hmq_pkg::MODE_PUSH, pick_key(style), PAY_W'($urandom));
        repeat (HEAP_N + 2) offer_op(hmq_pkg::MODE_POP, KEY_W'($urandom), PAY_W'($urandom));
        settle();
        calm_stretch = 1'b0;
    endtask

    // receiver holds off for a long stretch while the sender keeps offering,
    // so the block fills its result register and stops taking operations
    task automatic test_output_stall();
        hold_left = HOLD_OFF;
        repeat (40) offer_op(hmq_pkg::MODE_PUSH, pick_key(0), PAY_W'($urandom));
        repeat (20) offer_op(($urandom_range(99) < 70) ? hmq_pkg::MODE_POP : hmq_pkg::MODE_PUSH,
                             pick_key(1), PAY_W'($urandom));
        settle();
    endtask

    // mixed traffic in phases that lean to push, to balance, then to pop
    task automatic test_random_mix();
        int push_pct;
        int style;
        for (int phase = 0; phase < 12; phase++) begin
            push_pct = (phase % 3 == 0) ? 75 : (phase % 3 == 1) ? 50 : 25;
            style    = phase % 4;
            repeat (100) begin
                offer_op(($urandom_range(99) < push_pct) ? hmq_pkg::MODE_PUSH
                                                         : hmq_pkg::MODE_POP,
                         pick_key(style), PAY_W'($urandom));
            end
        end
        settle();
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------

    initial begin
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_directed_ops();
        test_fill_to_full(1'b1, 0);
        test_fill_to_full(1'b0, 1);
        test_output_stall();
        test_random_mix();
        // fill the heap with extreme keys, then empty it, so the pops exercise deep sift-downs
        test_fill_to_full(1'b0, 2);

        // allow a late stray result to show up before the verdict
        repeat (40) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule

[sim.f]
rtl/hmq_pkg.sv
rtl/hmq_ram.sv
rtl/hmq_datapath.sv
rtl/hmq_ctrl.sv
rtl/binary_min_heap_queue_core.sv
rtl/hmq_checker.sv
bench/testbench.sv
